>>> hw/rtl/rmez_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmez_pkg: shared types and constants for the zyx euler angle block
// fixed point scales, cordic widths, arctangent table and case codes
// ----------------------------------------------------------------------------
package rmez_pkg;

	// matrix entries and angles carry this many fraction bits
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 18;
	localparam int MAG_W     = FRAC_BITS + 1;
	// cordic vector scale and angle accumulator scale
	localparam int Q_BITS    = 30;
	localparam int QS        = Q_BITS - FRAC_BITS;
	localparam int XW        = Q_BITS + 4;
	localparam int ZW        = 36;
	// square root radicand and root widths
	localparam int RAD_W     = 2 * Q_BITS + 2;
	localparam int ROOT_W    = Q_BITS + 1;
	localparam int SQ_W      = 2 * MAG_W;

	// output widths
	localparam int ROLL_W    = 19;
	localparam int PITCH_W   = 18;
	localparam int YAW_W     = 19;
	localparam int RND_W     = ZW - (32 - FRAC_BITS);

	// angles in q32 radians
	localparam logic signed [ZW-1:0] Q32_HALF_PI = 36'sd6746518853;
	localparam logic signed [ZW-1:0] Q32_PI      = 36'sd13493037705;

	// limits after rounding to the output scale
	localparam logic signed [RND_W-1:0] LIM_HALF_PI =
		RND_W'((Q32_HALF_PI + (ZW'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS));
	localparam logic signed [RND_W-1:0] LIM_PI =
		RND_W'((Q32_PI + (ZW'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS));

	typedef enum logic [1:0] {
		CASE_NORMAL   = 2'd0,
		CASE_LOCK_POS = 2'd1,
		CASE_LOCK_NEG = 2'd2
	} case_code_t;

	// result word as it leaves the pipeline
	typedef struct packed {
		case_code_t                 code;
		logic signed [YAW_W-1:0]    yaw;
		logic signed [PITCH_W-1:0]  pitch;
		logic signed [ROLL_W-1:0]   roll;
	} out_word_t;

	// arctangent of 2^-i in q32, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q32(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0:       a = 36'sd3373259426;
			1:       a = 36'sd1991351318;
			2:       a = 36'sd1052175346;
			3:       a = 36'sd534100635;
			4:       a = 36'sd268086748;
			5:       a = 36'sd134174063;
			6:       a = 36'sd67103404;
			7:       a = 36'sd33553749;
			8:       a = 36'sd16777131;
			9:       a = 36'sd8388597;
			10:      a = 36'sd4194303;
			11:      a = 36'sd2097152;
			default: a = ZW'(1) <<< (32 - i);
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rmez_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmez_cordic: pipelined vectoring cordic for atan2
// one pre-rotation stage and one register stage per micro-rotation
// ----------------------------------------------------------------------------
module rmez_cordic #(
	parameter int STEPS = 18
) (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire logic signed [rmez_pkg::XW-1:0]  y_in,
	input  wire logic signed [rmez_pkg::XW-1:0]  x_in,
	output logic signed [rmez_pkg::ZW-1:0]       z_out
);

	logic signed [rmez_pkg::XW-1:0] x_s [0:STEPS];
	logic signed [rmez_pkg::XW-1:0] y_s [0:STEPS];
	logic signed [rmez_pkg::ZW-1:0] z_s [0:STEPS];
	logic                           zero_s [0:STEPS];

	// pre-rotation into the right half plane, zero vector flag
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[rmez_pkg::XW-1] && !y_in[rmez_pkg::XW-1]) begin
				x_s[0] <= y_in;
				y_s[0] <= -x_in;
				z_s[0] <= rmez_pkg::Q32_HALF_PI;
			end else if (x_in[rmez_pkg::XW-1]) begin
				x_s[0] <= -y_in;
				y_s[0] <= x_in;
				z_s[0] <= -rmez_pkg::Q32_HALF_PI;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	// micro-rotations, shifts round toward minus infinity
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [rmez_pkg::ZW-1:0] ANG = rmez_pkg::atan_q32(i);
		logic signed [rmez_pkg::XW-1:0] xs;
		logic signed [rmez_pkg::XW-1:0] ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i][rmez_pkg::XW-1]) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ANG;
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ANG;
				end
			end
		end
	end

	// atan2 of the zero vector is zero
	assign z_out = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/rotation_matrix_to_euler_zyx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyx: zyx euler angles from a rotation matrix
// saturation, gimbal lock test, pipelined square root and three cordics
// ----------------------------------------------------------------------------
// Takes one matrix word per cycle while s_tready is high and returns roll,
// pitch and yaw in radians with 16 fraction bits, plus a case code on
// m_tuser. From input to the output buffer a word passes the saturation
// stage, the lock test stage, the bit-per-stage square root for the pitch
// cosine, the pre-rotation and micro-rotation stages of the atan2
// pipelines, and a rounding stage. The pipeline moves as a whole and feeds
// a two-word output buffer, so a word is taken every cycle while m_tready
// stays high; s_tready drops only when that buffer is full.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_zyx #(
	parameter int CORDIC_STEPS = 18
) (
	input  wire          clk,
	input  wire          arst_n,
	// gimbal lock margin register
	input  wire          cfg_wen,
	input  wire [16:0]   cfg_wdata,
	// input words
	input  wire          s_tvalid,
	output logic         s_tready,
	// entry_0_0, entry_0_1, entry_0_2, entry_1_0, entry_1_2, entry_2_0,
	// entry_2_2, 18 bits each, two zero bits on top
	input  wire [127:0]  s_tdata,
	// output words
	output logic         m_tvalid,
	input  wire          m_tready,
	// roll_angle 19, pitch_angle 18, yaw_angle 19
	output logic [55:0]  m_tdata,
	// case_code 2
	output logic [1:0]   m_tuser
);

	localparam int IN_W   = rmez_pkg::IN_W;
	localparam int ROOT_W = rmez_pkg::ROOT_W;
	localparam int RAD_W  = rmez_pkg::RAD_W;
	localparam int XW     = rmez_pkg::XW;
	localparam int ZW     = rmez_pkg::ZW;
	localparam int RND_W  = rmez_pkg::RND_W;
	localparam int CS     = 2 + ROOT_W;
	localparam int L      = CS + CORDIC_STEPS + 2;
	localparam logic signed [IN_W-1:0] ONE = IN_W'(1) <<< rmez_pkg::FRAC_BITS;

	typedef struct packed {
		logic signed [IN_W-1:0] e02;
		logic signed [IN_W-1:0] ry;
		logic signed [IN_W-1:0] rx;
		logic signed [IN_W-1:0] yy;
		logic signed [IN_W-1:0] yx;
	} args_t;

	logic                                 en;
	logic [16:0]                          margin_q;
	logic                                 vld_s [0:L-1];
	rmez_pkg::case_code_t                 code_s [1:L-1];
	logic signed [IN_W-1:0]               ent_s1 [0:6];
	args_t                                args_s2;
	logic [rmez_pkg::SQ_W-1:0]            sq_s2;
	args_t                                args_sq [0:ROOT_W-1];
	logic [RAD_W-1:0]                     rem_sq [0:ROOT_W];
	logic [RAD_W-1:0]                     root_sq [0:ROOT_W];
	logic signed [XW-1:0]                 py, px, ry, rx, yy, yx;
	logic signed [ZW-1:0]                 zp, zr, zy;
	rmez_pkg::out_word_t                  res_so;
	rmez_pkg::out_word_t                  buf0_q, buf1_q;
	logic [1:0]                           cnt_q;
	logic                                 push, pop;
	logic [rmez_pkg::MAG_W-1:0]           mag;
	logic signed [IN_W:0]                 gap;

	// round a q32 angle to the output scale and clamp it
	function automatic logic signed [RND_W-1:0] q32_out(
		input logic signed [ZW-1:0]    z,
		input logic signed [RND_W-1:0] lim
	);
		logic signed [ZW-1:0] r;
		logic signed [ZW-1:0] l;
		r = (z + (ZW'(1) <<< (31 - rmez_pkg::FRAC_BITS))) >>> (32 - rmez_pkg::FRAC_BITS);
		l = ZW'(lim);
		if (r > l) r = l;
		if (r < -l) r = -l;
		return RND_W'(r);
	endfunction

	// pipeline advances while the output buffer has room
	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	// margin register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 17'd1;
		end else if (cfg_wen) begin
			margin_q <= cfg_wdata;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int k = 1; k < L; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 1: saturate entries to plus or minus one
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 7; k++) begin
				if ($signed(s_tdata[k*IN_W +: IN_W]) > ONE) begin
					ent_s1[k] <= ONE;
				end else if ($signed(s_tdata[k*IN_W +: IN_W]) < -ONE) begin
					ent_s1[k] <= -ONE;
				end else begin
					ent_s1[k] <= $signed(s_tdata[k*IN_W +: IN_W]);
				end
			end
		end
	end

	// stage 2: lock test, roll arguments, square of e02
	assign mag = ent_s1[2][IN_W-1] ? rmez_pkg::MAG_W'(-ent_s1[2])
	                               : rmez_pkg::MAG_W'(ent_s1[2]);
	assign gap = (IN_W+1)'(ONE) - (IN_W+1)'(mag);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2       <= rmez_pkg::SQ_W'(mag) * rmez_pkg::SQ_W'(mag);
			args_s2.e02 <= ent_s1[2];
			args_s2.yy  <= ent_s1[1];
			args_s2.yx  <= ent_s1[0];
			if (gap > $signed({2'b00, margin_q})) begin
				code_s[1]  <= rmez_pkg::CASE_NORMAL;
				args_s2.ry <= ent_s1[4];
				args_s2.rx <= ent_s1[6];
			end else if (ent_s1[2][IN_W-1]) begin
				code_s[1]  <= rmez_pkg::CASE_LOCK_POS;
				args_s2.ry <= ent_s1[3];
				args_s2.rx <= ent_s1[5];
			end else begin
				code_s[1]  <= rmez_pkg::CASE_LOCK_NEG;
				args_s2.ry <= -ent_s1[3];
				args_s2.rx <= -ent_s1[5];
			end
			// case code travels with the word
			for (int k = 2; k < L; k++) code_s[k] <= code_s[k-1];
		end
	end

	// square root of 2^60 - s^2, one root bit per stage
	assign rem_sq[0]  = (RAD_W'(1) << (2 * rmez_pkg::Q_BITS))
	                  - (RAD_W'(sq_s2) << (2 * rmez_pkg::QS));
	assign root_sq[0] = '0;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - j;
		logic [RAD_W-1:0] trial;
		assign trial = (root_sq[j] << (B + 1)) | (RAD_W'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				args_sq[j] <= (j == 0) ? args_s2 : args_sq[(j == 0) ? 0 : j-1];
				if (rem_sq[j] >= trial) begin
					rem_sq[j+1]  <= rem_sq[j] - trial;
					root_sq[j+1] <= root_sq[j] | (RAD_W'(1) << B);
				end else begin
					rem_sq[j+1]  <= rem_sq[j];
					root_sq[j+1] <= root_sq[j];
				end
			end
		end
	end

	// cordic inputs in q30
	assign py = XW'(args_sq[ROOT_W-1].e02) <<< rmez_pkg::QS;
	assign px = XW'(root_sq[ROOT_W]);
	assign ry = XW'(args_sq[ROOT_W-1].ry) <<< rmez_pkg::QS;
	assign rx = XW'(args_sq[ROOT_W-1].rx) <<< rmez_pkg::QS;
	assign yy = XW'(args_sq[ROOT_W-1].yy) <<< rmez_pkg::QS;
	assign yx = XW'(args_sq[ROOT_W-1].yx) <<< rmez_pkg::QS;

	rmez_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .y_in(py), .x_in(px), .z_out(zp)
	);
	rmez_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .y_in(ry), .x_in(rx), .z_out(zr)
	);
	rmez_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(en), .y_in(yy), .x_in(yx), .z_out(zy)
	);

	// last stage: rounding, clamping, lock overrides
	always_ff @(posedge clk) begin
		if (en) begin
			res_so.code <= code_s[L-2];
			res_so.roll <= rmez_pkg::ROLL_W'(q32_out(zr, rmez_pkg::LIM_PI));
			case (code_s[L-2])
				rmez_pkg::CASE_NORMAL: begin
					res_so.pitch <= rmez_pkg::PITCH_W'(q32_out(-zp, rmez_pkg::LIM_HALF_PI));
					res_so.yaw   <= rmez_pkg::YAW_W'(q32_out(zy, rmez_pkg::LIM_PI));
				end
				rmez_pkg::CASE_LOCK_POS: begin
					res_so.pitch <= rmez_pkg::PITCH_W'(rmez_pkg::LIM_HALF_PI);
					res_so.yaw   <= '0;
				end
				default: begin
					res_so.pitch <= rmez_pkg::PITCH_W'(-rmez_pkg::LIM_HALF_PI);
					res_so.yaw   <= '0;
				end
			endcase
		end
	end

	// two-word output buffer
	assign push = en && vld_s[L-1];
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) buf0_q <= res_so;
				else buf1_q <= res_so;
			end
			2'b01: begin
				buf0_q <= buf1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) buf0_q <= res_so;
				else begin
					buf0_q <= buf1_q;
					buf1_q <= res_so;
				end
			end
			default: begin
				buf0_q <= buf0_q;
			end
		endcase
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {buf0_q.yaw, buf0_q.pitch, buf0_q.roll};
	assign m_tuser  = buf0_q.code;

endmodule
`default_nettype wire

>>> hw/rtl/rmez_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmez_checker: port level checks for the zyx euler angle block
// lock results, roll range and output word stability
// ----------------------------------------------------------------------------
module rmez_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [55:0]  m_tdata,
	input wire [1:0]   m_tuser
);

	// in lock yaw is zero
	a_lock_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != rmez_pkg::CASE_NORMAL) |-> m_tdata[55:37] == '0)
		else $error("yaw not zero in gimbal lock");

	// positive lock gives plus half pi
	a_lock_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == rmez_pkg::CASE_LOCK_POS)
		|-> $signed(m_tdata[36:19]) == rmez_pkg::LIM_HALF_PI)
		else $error("pitch not plus half pi in lock");

	// roll stays within plus or minus pi
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[18:0]) <= rmez_pkg::LIM_PI)
		          && ($signed(m_tdata[18:0]) >= -rmez_pkg::LIM_PI))
		else $error("roll out of range");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

endmodule

bind rotation_matrix_to_euler_zyx rmez_checker u_rmez_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

>>> sim/euler_zyx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zyx_checker: angle predictor and result checker
// watches both stream channels, predicts roll, pitch, yaw and case code for
// every accepted matrix word and compares each result word in order
// ----------------------------------------------------------------------------
module euler_zyx_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_wen,
	input  wire [16:0]   cfg_wdata,
	input  wire          s_tvalid,
	input  wire          s_tready,
	input  wire [127:0]  s_tdata,
	input  wire          m_tvalid,
	input  wire          m_tready,
	input  wire [55:0]   m_tdata,
	input  wire [1:0]    m_tuser,
	output int           fail_count,
	output int           pending_count
);

	localparam int FRAC_BITS = rmez_pkg::FRAC_BITS;
	localparam int QS        = rmez_pkg::QS;
	localparam int ROLL_W    = rmez_pkg::ROLL_W;
	localparam int PITCH_W   = rmez_pkg::PITCH_W;
	localparam int YAW_W     = rmez_pkg::YAW_W;
	localparam longint ONE = 64'sd1 << FRAC_BITS;

	typedef struct {
		logic signed [ROLL_W-1:0]  roll;
		logic signed [PITCH_W-1:0] pitch;
		logic signed [YAW_W-1:0]   yaw;
		rmez_pkg::case_code_t      code;
	} angles_t;

	logic [16:0] lock_margin;
	angles_t     angle_queue[$];

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// saturate one 18 bit entry to +-1.0
	function automatic longint sat_entry(logic [17:0] raw);
		longint v;
		v = longint'($signed(raw));
		if (v > ONE) v = ONE;
		if (v < -ONE) v = -ONE;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// vectoring cordic, q30 in, q32 radians out
	function automatic longint atan2_q32(longint y, longint x);
		longint z, t, a, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 64'sd6746518853;
			end else begin
				t = x; x = -y; y = t; z = -64'sd6746518853;
			end
		end
		for (int i = 0; i < 18; i++) begin
			case (i)
				0: a = 64'sd3373259426;  1: a = 1991351318; 2: a = 1052175346;
				3: a = 534100635;   4: a = 268086748;  5: a = 134174063;
				6: a = 67103404;    7: a = 33553749;   8: a = 16777131;
				9: a = 8388597;     10: a = 4194303;   11: a = 2097152;
				default: a = 64'sd1 << (32 - i);
			endcase
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y < 0) begin
				x = x - ys; y = y + xs; z -= a;
			end else begin
				x = x + ys; y = y - xs; z += a;
			end
		end
		return z;
	endfunction

	// q32 to output scale, round half up, then clamp
	function automatic longint round_clamp(longint z, longint lim_q32);
		longint r, lim;
		r = floor_shr(z + (64'sd1 << (31 - FRAC_BITS)), 32 - FRAC_BITS);
		lim = floor_shr(lim_q32 + (64'sd1 << (31 - FRAC_BITS)), 32 - FRAC_BITS);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic angles_t predict_angles(logic [127:0] d, logic [16:0] margin);
		longint e00, e01, e02, e10, e12, e20, e22, mag, s, c;
		longint unsigned sa;
		angles_t res;
		longint half_pi, pi_q;
		half_pi = 64'sd6746518853;
		pi_q = 64'sd13493037705;
		e00 = sat_entry(d[17:0]);
		e01 = sat_entry(d[35:18]);
		e02 = sat_entry(d[53:36]);
		e10 = sat_entry(d[71:54]);
		e12 = sat_entry(d[89:72]);
		e20 = sat_entry(d[107:90]);
		e22 = sat_entry(d[125:108]);
		mag = e02 < 0 ? -e02 : e02;
		if (ONE - mag > longint'(margin)) begin
			s = e02 <<< QS;
			sa = s < 0 ? -s : s;
			c = int_sqrt((64'd1 << 60) - sa * sa);
			res.pitch = PITCH_W'(round_clamp(-atan2_q32(s, c), half_pi));
			res.roll = ROLL_W'(round_clamp(atan2_q32(e12 <<< QS, e22 <<< QS), pi_q));
			res.yaw = YAW_W'(round_clamp(atan2_q32(e01 <<< QS, e00 <<< QS), pi_q));
			res.code = rmez_pkg::CASE_NORMAL;
		end else if (e02 < 0) begin
			res.pitch = PITCH_W'(round_clamp(half_pi, half_pi));
			res.roll = ROLL_W'(round_clamp(atan2_q32(e10 <<< QS, e20 <<< QS), pi_q));
			res.yaw = '0;
			res.code = rmez_pkg::CASE_LOCK_POS;
		end else begin
			res.pitch = PITCH_W'(-round_clamp(half_pi, half_pi));
			res.roll = ROLL_W'(round_clamp(atan2_q32((-e10) <<< QS, (-e20) <<< QS), pi_q));
			res.yaw = '0;
			res.code = rmez_pkg::CASE_LOCK_NEG;
		end
		return res;
	endfunction

	// track margin, predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		angles_t exp_w;
		if (!arst_n) begin
			lock_margin = 17'd1;
			fail_count = 0;
			angle_queue.delete();
		end else begin
			if (cfg_wen) lock_margin = cfg_wdata;
			if (s_tvalid && s_tready)
				angle_queue.insert(angle_queue.size(), predict_angles(s_tdata, lock_margin));
			if (m_tvalid && m_tready) begin
				if (angle_queue.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					exp_w = angle_queue.pop_front();
					if (m_tdata[18:0] !== exp_w.roll) begin
						$error("roll_angle exp %0d got %0d", exp_w.roll, $signed(m_tdata[18:0]));
						fail_count++;
					end
					if (m_tdata[36:19] !== exp_w.pitch) begin
						$error("pitch_angle exp %0d got %0d", exp_w.pitch,
							$signed(m_tdata[36:19]));
						fail_count++;
					end
					if (m_tdata[55:37] !== exp_w.yaw) begin
						$error("yaw_angle exp %0d got %0d", exp_w.yaw, $signed(m_tdata[55:37]));
						fail_count++;
					end
					if (m_tuser !== exp_w.code) begin
						$error("case_code exp %0d got %0d", exp_w.code, m_tuser);
						fail_count++;
					end
				end
			end
		end
		pending_count = angle_queue.size();
	end

endmodule

>>> sim/rotation_matrix_to_euler_zyx_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyx_tb: stimulus and verdict for the euler block
// directed corner matrices, then random and near-lock words under several
// lock margins, with random stalls on both sides and one long output hold
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_zyx_tb;

	localparam int LATENCY = 60;
	localparam int WATCH_LIMIT = 5000;

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [16:0]  cfg_wdata;
	logic         s_tvalid;
	wire          s_tready;
	logic [127:0] s_tdata;
	wire          m_tvalid;
	logic         m_tready;
	wire [55:0]   m_tdata;
	wire [1:0]    m_tuser;
	int           fail_count;
	int           pending_count;
	bit           calm_phase;
	bit           long_hold;
	int           idle_cycles;

	rotation_matrix_to_euler_zyx i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	euler_zyx_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// random entry: mostly in range, sometimes any 18 bit pattern
	function automatic logic [17:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return 18'($urandom);
			1: return 18'(65536);
			2: return 18'(-65536);
			default: return 18'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	// e02 near +-1 so the lock test goes both ways
	function automatic logic [17:0] near_pole(int spread);
		int v;
		v = 65536 - $urandom_range(0, spread);
		return $urandom_range(0, 1) ? 18'(v) : 18'(-v);
	endfunction

	function automatic logic [127:0] pack_matrix(logic [17:0] e00, e01, e02, e10,
		e12, e20, e22);
		return {2'b00, e22, e20, e12, e10, e02, e01, e00};
	endfunction

	task automatic send_word(logic [127:0] d);
		int gap;
		if (!calm_phase && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 7);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic set_margin(logic [16:0] m);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic random_phase(int count, int spread);
		for (int n = 0; n < count; n++) begin
			logic [17:0] e02;
			e02 = ($urandom_range(0, 2) == 0) ? near_pole(spread) : rand_entry();
			send_word(pack_matrix(rand_entry(), rand_entry(), e02, rand_entry(),
				rand_entry(), rand_entry(), rand_entry()));
		end
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		int burst;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (200) @(negedge clk);
				long_hold = 1'b0;
			end
			if (!calm_phase && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				burst = $urandom_range(1, 7);
				repeat (burst - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any accepted word
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				idle_cycles = 0;
			else if (++idle_cycles >= WATCH_LIMIT) begin
				$display("rotation_matrix_to_euler_zyx: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [17:0] p1, m1;
		p1 = 18'(65536);
		m1 = 18'(-65536);
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm_phase = 1'b0;
		long_hold = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: identity, poles, zero vectors, saturation, negative x
		send_word(pack_matrix(p1, 0, 0, 0, 0, 0, p1));
		send_word(pack_matrix(0, 0, m1, p1, 0, 0, 0));
		send_word(pack_matrix(0, 0, p1, m1, 0, 0, m1));
		send_word(pack_matrix(0, 0, 0, 0, 0, 0, 0));
		send_word(pack_matrix(0, 0, m1, 0, 0, 0, 0));
		send_word(pack_matrix(0, 0, p1, 0, 0, 0, 0));
		send_word(pack_matrix(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000, 18'h1ffff,
			18'h20000, 18'h20000));
		send_word(pack_matrix(m1, 0, 0, 0, 0, 0, m1));
		send_word(pack_matrix(m1, 18'(-1), 0, 0, 18'(-1), 0, m1));
		send_word(pack_matrix(m1, 1, 18'(65535), 0, 1, 0, m1));
		send_word(pack_matrix(m1, 1, 18'(-65535), 18'(-3), 1, 18'(-5), m1));
		send_word(pack_matrix(18'h3ffff, 18'h3ffff, 18'h3ffff, 18'h3ffff, 18'h3ffff,
			18'h3ffff, 18'h3ffff));
		send_word(pack_matrix(0, p1, 18'(46341), m1, m1, p1, 0));

		random_phase(250, 8);

		// long output hold while words keep arriving
		long_hold = 1'b1;
		random_phase(150, 16);

		set_margin(17'd0);
		send_word(pack_matrix(p1, 0, 18'(65535), 0, 0, 0, p1));
		random_phase(250, 4);
		set_margin(17'd65536);
		random_phase(200, 65536);
		set_margin(17'd1000);
		random_phase(300, 2000);
		set_margin(17'($urandom_range(0, 65536)));
		random_phase(200, 65536);
		set_margin(17'd1);
		calm_phase = 1'b1;
		random_phase(200, 4);
		s_tvalid <= 1'b0;

		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
		if (fail_count == 0)
			$display("rotation_matrix_to_euler_zyx: match");
		else
			$display("rotation_matrix_to_euler_zyx: mismatch");
		$finish;
	end

endmodule
